// ===== hdl/ci128_pkg.sv =====
`timescale 1ns / 1ps

package ci128_pkg;

    localparam int HALF_W    = 64;
    localparam int WORD_W    = 2 * HALF_W;
    localparam int DIV_STEPS = WORD_W;
    localparam int MUL_LAT   = 6;
    localparam int MUL_DLY   = DIV_STEPS - MUL_LAT;

    typedef enum logic [2:0] {
        CMD_SMUL = 3'd0,
        CMD_UMUL = 3'd1,
        CMD_SDIV = 3'd2,
        CMD_SREM = 3'd3,
        CMD_UDIV = 3'd4,
        CMD_UREM = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic [2:0] cmd;
        logic       neg_a;
        logic       neg_b;
        logic       b_zero;
        logic       min_over_m1;
    } t_tag;

endpackage

// ===== hdl/ci128_mul_pipe.sv =====
`timescale 1ns / 1ps

module ci128_mul_pipe (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_signed,
    input  logic [ci128_pkg::WORD_W-1:0]     i_a,
    input  logic [ci128_pkg::WORD_W-1:0]     i_b,
    output logic [ci128_pkg::WORD_W-1:0]     o_prod,
    output logic                             o_ovf
);

    typedef struct packed {
        logic [ci128_pkg::WORD_W-1:0] a;
        logic [ci128_pkg::WORD_W-1:0] b;
        logic                         sg;
    } t_mop;

    t_mop        r_op [1:5];
    logic [63:0] r_pp [0:15];
    logic [63:0] w_pp [0:15];
    logic [65:0] r_col [0:6];
    logic [65:0] w_col [0:6];
    logic [255:0] r_even, r_odd, w_even, w_odd;
    logic [255:0] r_p;
    logic [127:0] r_top, r_plo, r_phi;
    logic [127:0] w_top2;
    logic [127:0] r_prod;
    logic         r_ovf;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_pp[4*i+j] = 64'(i_a[32*i +: 32]) * 64'(i_b[32*j +: 32]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            w_col[k] = '0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if (i + j == k) begin
                        w_col[k] = w_col[k] + 66'(r_pp[4*i+j]);
                    end
                end
            end
        end
    end

    always_comb begin
        w_even = '0;
        w_odd  = '0;
        for (int k = 0; k < 7; k++) begin
            if (k % 2 == 0) begin
                w_even = w_even + (256'(r_col[k]) << (32 * k));
            end else begin
                w_odd = w_odd + (256'(r_col[k]) << (32 * k));
            end
        end
    end

    assign w_top2 = r_top - (r_op[5].b[127] ? r_op[5].a : '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op[1] <= '{a: i_a, b: i_b, sg: i_signed};
            for (int s = 2; s <= 5; s++) begin
                r_op[s] <= r_op[s-1];
            end
            for (int m = 0; m < 16; m++) begin
                r_pp[m] <= w_pp[m];
            end
            for (int k = 0; k < 7; k++) begin
                r_col[k] <= w_col[k];
            end
            r_even <= w_even;
            r_odd  <= w_odd;
            r_p    <= r_even + r_odd;
            r_top  <= r_p[255:128] - (r_op[4].a[127] ? r_op[4].b : '0);
            r_plo  <= r_p[127:0];
            r_phi  <= r_p[255:128];
            r_prod <= r_plo;
            r_ovf  <= r_op[5].sg ? (w_top2 != {128{r_plo[127]}}) : (r_phi != '0);
        end
    end

    assign o_prod = r_prod;
    assign o_ovf  = r_ovf;

endmodule

// ===== hdl/ci128_div_pipe.sv =====
`timescale 1ns / 1ps

module ci128_div_pipe (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  ci128_pkg::t_tag                  i_tag,
    input  logic [ci128_pkg::WORD_W-1:0]     i_num,
    input  logic [ci128_pkg::WORD_W-1:0]     i_den,
    output logic                             o_valid,
    output ci128_pkg::t_tag                  o_tag,
    output logic [ci128_pkg::WORD_W-1:0]     o_quo,
    output logic [ci128_pkg::WORD_W-1:0]     o_rem
);

    localparam int W = ci128_pkg::WORD_W;
    localparam int N = ci128_pkg::DIV_STEPS;

    logic              r_valid [0:N-1];
    ci128_pkg::t_tag   r_tag   [0:N-1];
    logic [W-1:0]      r_rem   [0:N-1];
    logic [W-1:0]      r_num   [0:N-1];
    logic [W-1:0]      r_den   [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic              w_valid;
        ci128_pkg::t_tag   w_tag;
        logic [W-1:0]      w_rem, w_num, w_den;
        logic [W:0]        w_shift, w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_tag   = i_tag;
            assign w_rem   = '0;
            assign w_num   = i_num;
            assign w_den   = i_den;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_tag   = r_tag[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_num   = r_num[k-1];
            assign w_den   = r_den[k-1];
        end

        assign w_shift = {w_rem, w_num[W-1]};
        assign w_diff  = w_shift - {1'b0, w_den};
        assign w_ge    = w_shift >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= w_tag;
                r_rem[k] <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
                r_num[k] <= {w_num[W-2:0], w_ge};
                r_den[k] <= w_den;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_tag   = r_tag[N-1];
    assign o_quo   = r_num[N-1];
    assign o_rem   = r_rem[N-1];

endmodule

// ===== hdl/checked_int128_mul_div_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         a_high, a_low, b_high, b_low (256 bits)     command (3 bits)
// m_axis    out        result_high, result_low (128 bits)          status (2 bits)
//
// One transaction is accepted per clock while input ready is high.
// The divider retires one quotient bit per stage.
// Reset is synchronous and clears only the valid bits, not the data registers.
// A stall on the output is absorbed by a skid register; input ready then drops
// for as long as the skid register is full, and nothing is lost or repeated.

module checked_int128_mul_div_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [255:0] i_s_axis_tdata,   // a_high, a_low, b_high, b_low
    input  logic [2:0]   i_s_axis_tuser,   // command
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // result_high, result_low
    output logic [1:0]   o_m_axis_tuser    // status
);

    localparam int W = ci128_pkg::WORD_W;
    localparam int H = ci128_pkg::HALF_W;
    localparam int D = ci128_pkg::MUL_DLY;

    typedef struct packed {
        logic [W-1:0] prod;
        logic         ovf;
    } t_mres;

    logic          w_en, w_acc;
    logic          r_s0_v, r_s1_v;
    logic [2:0]    r_s0_cmd;
    logic [W-1:0]  r_s0_a, r_s0_b, r_s1_a, r_s1_b, r_s1_num, r_s1_den;
    ci128_pkg::t_tag r_s1_tag;
    logic          r_s1_smul;
    logic          w_sg, w_na, w_nb;

    logic [W-1:0]  w_prod;
    logic          w_movf;
    t_mres         r_mdly [0:D-1];

    logic            w_dv;
    ci128_pkg::t_tag w_dtag;
    logic [W-1:0]    w_quo, w_rem;

    logic [W-1:0]  n_res;
    logic [1:0]    n_st;

    logic          r_ov, r_skid_v;
    logic [W-1:0]  r_ores, r_skid_res;
    logic [1:0]    r_ost, r_skid_st;

    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= w_acc;
            r_s1_v <= r_s0_v;
        end
    end

    assign w_sg = (r_s0_cmd == ci128_pkg::CMD_SDIV) || (r_s0_cmd == ci128_pkg::CMD_SREM);
    assign w_na = w_sg && r_s0_a[W-1];
    assign w_nb = w_sg && r_s0_b[W-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_cmd  <= i_s_axis_tuser;
            r_s0_a    <= {i_s_axis_tdata[H-1:0], i_s_axis_tdata[2*H-1:H]};
            r_s0_b    <= {i_s_axis_tdata[3*H-1:2*H], i_s_axis_tdata[4*H-1:3*H]};
            r_s1_a    <= r_s0_a;
            r_s1_b    <= r_s0_b;
            r_s1_smul <= r_s0_cmd == ci128_pkg::CMD_SMUL;
            r_s1_num  <= w_na ? -r_s0_a : r_s0_a;
            r_s1_den  <= w_nb ? -r_s0_b : r_s0_b;
            r_s1_tag  <= '{cmd: r_s0_cmd, neg_a: w_na, neg_b: w_nb,
                           b_zero: r_s0_b == '0,
                           min_over_m1: (r_s0_a == {1'b1, {(W-1){1'b0}}}) &&
                                        (r_s0_b == '1)};
        end
    end

    ci128_mul_pipe u_mul (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_signed (r_s1_smul),
        .i_a      (r_s1_a),
        .i_b      (r_s1_b),
        .o_prod   (w_prod),
        .o_ovf    (w_movf)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mdly[0] <= '{prod: w_prod, ovf: w_movf};
            for (int k = 1; k < D; k++) begin
                r_mdly[k] <= r_mdly[k-1];
            end
        end
    end

    ci128_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_v),
        .i_tag   (r_s1_tag),
        .i_num   (r_s1_num),
        .i_den   (r_s1_den),
        .o_valid (w_dv),
        .o_tag   (w_dtag),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_comb begin
        n_res = '0;
        n_st  = ci128_pkg::ST_OK;
        case (w_dtag.cmd)
            ci128_pkg::CMD_SMUL, ci128_pkg::CMD_UMUL: begin
                n_res = r_mdly[D-1].prod;
                n_st  = r_mdly[D-1].ovf ? ci128_pkg::ST_OVERFLOW : ci128_pkg::ST_OK;
            end
            ci128_pkg::CMD_SDIV, ci128_pkg::CMD_SREM: begin
                if (w_dtag.b_zero) begin
                    n_st = ci128_pkg::ST_DIVZERO;
                end else if (w_dtag.min_over_m1) begin
                    n_st = ci128_pkg::ST_OVERFLOW;
                end else if (w_dtag.cmd == ci128_pkg::CMD_SDIV) begin
                    n_res = (w_dtag.neg_a != w_dtag.neg_b) ? -w_quo : w_quo;
                end else begin
                    n_res = w_dtag.neg_a ? -w_rem : w_rem;
                end
            end
            ci128_pkg::CMD_UDIV, ci128_pkg::CMD_UREM: begin
                if (w_dtag.b_zero) begin
                    n_st = ci128_pkg::ST_DIVZERO;
                end else begin
                    n_res = (w_dtag.cmd == ci128_pkg::CMD_UDIV) ? w_quo : w_rem;
                end
            end
            default: begin
                n_res = '0;
                n_st  = ci128_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_ov && i_m_axis_tready) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else if (!(w_en && w_dv)) begin
                r_ov <= 1'b0;
            end
        end else if (!r_ov) begin
            r_ov <= w_en && w_dv;
        end else if (w_en && w_dv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && i_m_axis_tready && r_skid_v) begin
            r_ores <= r_skid_res;
            r_ost  <= r_skid_st;
        end else if (!r_ov || i_m_axis_tready) begin
            r_ores <= n_res;
            r_ost  <= n_st;
        end
        if (r_ov && !i_m_axis_tready && w_en && w_dv) begin
            r_skid_res <= n_res;
            r_skid_st  <= n_st;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_ores[H-1:0], r_ores[W-1:H]};
    assign o_m_axis_tuser  = r_ost;

    a_skid_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid register holds a result while the output is empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_m_axis_tready |=> r_ov && $stable(r_ores) && $stable(r_ost))
        else $error("stalled result changed");

    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_ost == ci128_pkg::ST_DIVZERO) |-> (r_ores == '0))
        else $error("divide by zero with a nonzero result");

endmodule
